@@ rtl/core/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, defaults and constants for the escape-time point evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int Z_W             = 32;
  localparam int PROD_W          = 2 * Z_W;
  localparam int FRAC_BITS_DEF   = 28;
  localparam int ITER_LIMIT_DEF  = 4096;

  localparam int MAX_ITER_W      = 13;
  localparam int COLOUR_W        = 8;
  localparam int ITER_OUT_W      = 13;

  localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 13'd192;

  localparam logic [COLOUR_W-1:0] COLOUR_BASE = 8'd16;
  localparam logic [COLOUR_W-1:0] COLOUR_STEP = 8'd13;
  localparam logic [COLOUR_W:0]   COLOUR_MOD  = 9'd216;

endpackage

@@ rtl/core/mbe_if.sv @@
// ----------------------------------------------------------------------------
// mbe_in_if / mbe_out_if
// Valid/ready channels for the point word and the result word.
// ----------------------------------------------------------------------------
interface mbe_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mbe_pkg::Z_W-1:0]   cx;
  logic signed [mbe_pkg::Z_W-1:0]   cy;

  modport source (output valid, output cx, output cy, input ready);
  modport sink   (input valid, input cx, input cy, output ready);
endinterface

interface mbe_out_if;
  logic                                valid;
  logic                                ready;
  logic [mbe_pkg::COLOUR_W-1:0]        colour;
  logic [mbe_pkg::ITER_OUT_W-1:0]      iterations;
  logic                                inside_res;

  modport source (output valid, output colour, output iterations, output inside_res,
                  input ready);
  modport sink   (input valid, input colour, input iterations, input inside_res,
                  output ready);
endinterface

@@ rtl/core/mandelbrot_escape_time_point.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_point
// Escape-time evaluation of one complex point with a 256-color index.
// ----------------------------------------------------------------------------
// Takes one point c (cx, cy, signed, FRAC_BITS fraction bits) and iterates
// z = z^2 + c from zero until |z|^2 >= 4 or min(max_iter, ITER_LIMIT)
// updates are done. One 32x32 multiplier is shared for zx*zy, zx*zx and
// zy*zy, so each update steps through CHECK, MXY, WXY, MXX, MYY and WYY.
// The input is not ready while a point is in flight. The result word sits
// in an output register; the next point can be taken while it waits, and
// a finished point holds until that register is free. Write max_iter
// through cfg_wdata only while idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_point #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mbe_pkg::MAX_ITER_W-1:0]    cfg_wdata,
  mbe_in_if.sink                            in_ch,
  mbe_out_if.source                         out_ch
);

  localparam int Z_W    = mbe_pkg::Z_W;
  localparam int PROD_W = mbe_pkg::PROD_W;
  localparam int CNT_W  = $clog2(ITER_LIMIT + 1);
  localparam int LIM_W  = (CNT_W > mbe_pkg::MAX_ITER_W) ? CNT_W : mbe_pkg::MAX_ITER_W;
  localparam int THR_SH = 2 * FRAC_BITS + 2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_MXY   = 7'b0000100,
    ST_WXY   = 7'b0001000,
    ST_MXX   = 7'b0010000,
    ST_MYY   = 7'b0100000,
    ST_WYY   = 7'b1000000
  } state_t;

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-Z_W:0] top;
    top = v[PROD_W-1:Z_W-1];
    if (top == '0 || top == '1) begin
      sat_z = v[Z_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat_z = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      sat_z = {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

  state_t                           state_r, state_nxt;
  logic [mbe_pkg::MAX_ITER_W-1:0]   max_iter_r;
  logic signed [Z_W-1:0]            cx_r, cy_r, zx_r, zy_r;
  logic signed [PROD_W-1:0]         x2_r, y2_r;
  logic [CNT_W-1:0]                 cnt_r, limit_r;
  logic [mbe_pkg::COLOUR_W-1:0]     col_r;
  logic                             out_valid_r;
  logic [mbe_pkg::COLOUR_W-1:0]     out_colour_r;
  logic [mbe_pkg::ITER_OUT_W-1:0]   out_iter_r;
  logic                             out_inside_r;

  logic signed [Z_W-1:0]            mul_a, mul_b;
  logic signed [PROD_W-1:0]         prod_r;
  logic [PROD_W-1:0]                mag;
  logic                             below_thr;
  logic                             keep_going;
  logic                             out_free;
  logic                             in_fire;
  logic [LIM_W-1:0]                 lim_ext;
  logic [CNT_W-1:0]                 limit_nxt;
  logic signed [PROD_W-1:0]         diff, nzx_w, nzy_w;
  logic [mbe_pkg::COLOUR_W:0]       col_add;
  logic [mbe_pkg::COLOUR_W-1:0]     col_nxt;
  logic                             is_inside;

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign mul_a = (state_r == ST_MYY) ? zy_r : zx_r;
  assign mul_b = (state_r == ST_MXX) ? zx_r : zy_r;

  assign mag = x2_r + y2_r;

  generate
    if (THR_SH >= PROD_W) begin : g_no_thr
      assign below_thr = 1'b1;
    end else begin : g_thr
      assign below_thr = ~|mag[PROD_W-1:THR_SH];
    end
  endgenerate

  assign keep_going = (cnt_r < limit_r) && below_thr;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire    = in_ch.valid && in_ch.ready;

  assign lim_ext   = LIM_W'(max_iter_r);
  assign limit_nxt = (lim_ext > LIM_W'(ITER_LIMIT)) ? CNT_W'(ITER_LIMIT) : CNT_W'(lim_ext);

  assign diff  = x2_r - y2_r;
  assign nzx_w = (diff >>> FRAC_BITS) + PROD_W'(cx_r);
  assign nzy_w = (prod_r >>> (FRAC_BITS - 1)) + PROD_W'(cy_r);

  assign col_add = {1'b0, col_r} + {1'b0, mbe_pkg::COLOUR_STEP};
  assign col_nxt = (col_add >= mbe_pkg::COLOUR_MOD) ?
                   mbe_pkg::COLOUR_W'(col_add - mbe_pkg::COLOUR_MOD) :
                   mbe_pkg::COLOUR_W'(col_add);

  assign is_inside = (cnt_r == limit_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (keep_going) begin
          state_nxt = ST_MXY;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MXY:  state_nxt = ST_WXY;
      ST_WXY:  state_nxt = ST_MXX;
      ST_MXX:  state_nxt = ST_MYY;
      ST_MYY:  state_nxt = ST_WYY;
      ST_WYY:  state_nxt = ST_CHECK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_iter_r  <= mbe_pkg::MAX_ITER_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_iter_r <= cfg_wdata;
      if (state_r == ST_CHECK && !keep_going && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cx_r    <= in_ch.cx;
          cy_r    <= in_ch.cy;
          zx_r    <= '0;
          zy_r    <= '0;
          x2_r    <= '0;
          y2_r    <= '0;
          cnt_r   <= '0;
          col_r   <= '0;
          limit_r <= limit_nxt;
        end
      end
      ST_CHECK: begin
        if (!keep_going && out_free) begin
          out_colour_r <= is_inside ? '0 : (mbe_pkg::COLOUR_BASE + col_r);
          out_iter_r   <= mbe_pkg::ITER_OUT_W'(cnt_r);
          out_inside_r <= is_inside;
        end
      end
      ST_WXY: begin
        zx_r  <= sat_z(nzx_w);
        zy_r  <= sat_z(nzy_w);
        cnt_r <= cnt_r + 1'b1;
        col_r <= col_nxt;
      end
      ST_MYY: x2_r <= prod_r;
      ST_WYY: y2_r <= prod_r;
      ST_MXY, ST_MXX: begin
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.colour     = out_colour_r;
  assign out_ch.iterations = out_iter_r;
  assign out_ch.inside_res = out_inside_r;

endmodule

@@ rtl/core/mbe_mul.sv @@
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module mbe_mul (
  input  logic                              clk,
  input  logic signed [mbe_pkg::Z_W-1:0]    a,
  input  logic signed [mbe_pkg::Z_W-1:0]    b,
  output logic signed [mbe_pkg::PROD_W-1:0] p_r
);

  logic signed [mbe_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = mbe_pkg::PROD_W'(a) * mbe_pkg::PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
